// ===== rtl/core/vrpf_pkg.sv =====
// Package for the video RTP payload fragmenter.
// Holds constants, register codes and shared types; no dependencies.
package vrpf_pkg;

	// Packet header geometry
	localparam int HDR_BYTES       = 24;
	localparam int HDR_IDX_W       = 5;
	localparam int MIN_PACKET      = 25;
	localparam int COUNTER_W       = 22;
	localparam logic [31:0] FOURCC_AVC1 = 32'h4156_4331;

	// Frame length width default and the front/back queue depth
	localparam int LENGTH_BITS_DEF = 24;
	localparam int QUEUE_DEPTH     = 2;

	// Configuration port geometry
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_PACKET = 3'd0,
		REG_WIDTH      = 3'd1,
		REG_HEIGHT     = 3'd2,
		REG_RATE       = 3'd3,
		REG_FRACTIONAL = 3'd4,
		REG_INTERLACE  = 3'd5,
		REG_TILE       = 3'd6
	} cfg_reg_t;

	// Register file contents
	typedef struct packed {
		logic [15:0] max_packet_bytes;
		logic [15:0] frame_width;
		logic [15:0] frame_height;
		logic [9:0]  frame_rate;
		logic        fractional_rate;
		logic [2:0]  interlace_mode;
		logic [9:0]  tile_index;
	} cfg_t;

	// Per-beat classification made by the front
	typedef struct packed {
		logic hdr;
		logic pend;
		logic fend;
	} flags_t;

	// Queue head status seen by the back
	typedef struct packed {
		logic valid;
		logic pop;
	} queue_ctl_t;

endpackage

// ===== rtl/core/vrpf_ifs.sv =====
// Channel interfaces of the fragmenter: payload in, packets out, register writes.
// Depends on vrpf_pkg.
interface vrpf_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  data_byte;
	logic [23:0] frame_bytes;

	modport source (output valid, data_byte, frame_bytes, input ready);
	modport sink   (input valid, data_byte, frame_bytes, output ready);
endinterface

interface vrpf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       packet_end;
	logic       frame_end;

	modport source (output valid, out_byte, packet_end, frame_end, input ready);
	modport sink   (input valid, out_byte, packet_end, frame_end, output ready);
endinterface

interface vrpf_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [vrpf_pkg::CFG_IDX_W-1:0]    index;
	logic [vrpf_pkg::CFG_DATA_W-1:0]   data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/vrpf_regs.sv =====
// Configuration register file of the fragmenter.
// Depends on vrpf_pkg and vrpf_cfg_if.
module vrpf_regs (
	input  logic               clk,
	input  logic               arst_n,
	vrpf_cfg_if.sink           cfg,
	output vrpf_pkg::cfg_t     regs
);

	vrpf_pkg::cfg_t regs_q;
	logic           wr;

	assign cfg.ready = 1'b1;
	assign wr        = cfg.valid & cfg.ready;
	assign regs      = regs_q;

	// Register writes; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.max_packet_bytes <= 16'd1436;
			regs_q.frame_width      <= '0;
			regs_q.frame_height     <= '0;
			regs_q.frame_rate       <= 10'd25;
			regs_q.fractional_rate  <= 1'b0;
			regs_q.interlace_mode   <= '0;
			regs_q.tile_index       <= '0;
		end else if (wr) begin
			case (vrpf_pkg::cfg_reg_t'(cfg.index))
				vrpf_pkg::REG_MAX_PACKET: regs_q.max_packet_bytes <= cfg.data;
				vrpf_pkg::REG_WIDTH:      regs_q.frame_width      <= cfg.data;
				vrpf_pkg::REG_HEIGHT:     regs_q.frame_height     <= cfg.data;
				vrpf_pkg::REG_RATE:       regs_q.frame_rate       <= cfg.data[9:0];
				vrpf_pkg::REG_FRACTIONAL: regs_q.fractional_rate  <= cfg.data[0];
				vrpf_pkg::REG_INTERLACE:  regs_q.interlace_mode   <= cfg.data[2:0];
				vrpf_pkg::REG_TILE:       regs_q.tile_index       <= cfg.data[9:0];
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/core/vrpf_front.sv =====
// Front of the fragmenter: tracks frame and packet position and classifies
// each payload beat. Depends on vrpf_pkg and vrpf_in_if.
module vrpf_front #(
	parameter int LENGTH_BITS = vrpf_pkg::LENGTH_BITS_DEF,
	parameter int ENTRY_W     = 8 + 3 + 2 * LENGTH_BITS + vrpf_pkg::COUNTER_W
) (
	input  logic               clk,
	input  logic               arst_n,
	vrpf_in_if.sink            payload,
	input  vrpf_pkg::cfg_t     regs,
	input  logic               full,
	output logic               push,
	output logic [ENTRY_W-1:0] entry
);

	logic                             in_frame_q;
	logic [LENGTH_BITS-1:0]           length_q;
	logic [LENGTH_BITS-1:0]           offset_q;
	logic [LENGTH_BITS-1:0]           remain_q;
	logic [15:0]                      room_q;
	logic [vrpf_pkg::COUNTER_W-1:0]   counter_q;

	logic [LENGTH_BITS-1:0]           len_in;
	logic [LENGTH_BITS-1:0]           len_cur;
	logic [LENGTH_BITS-1:0]           off_cur;
	logic [LENGTH_BITS-1:0]           rem_cur;
	logic [15:0]                      room_cur;
	logic [15:0]                      limit;
	logic [15:0]                      cap;
	logic [15:0]                      room;
	logic [15:0]                      room_n;
	logic [LENGTH_BITS-1:0]           rem_n;
	vrpf_pkg::flags_t                 flags;

	assign payload.ready = ~full;
	assign push          = payload.valid & ~full;

	// Current position; a new frame starts from its first beat
	always_comb begin
		len_in   = LENGTH_BITS'(payload.frame_bytes);
		if (len_in == '0) begin
			len_in = LENGTH_BITS'(1);
		end
		len_cur  = in_frame_q ? length_q : len_in;
		off_cur  = in_frame_q ? offset_q : '0;
		rem_cur  = in_frame_q ? remain_q : len_in;
		room_cur = in_frame_q ? room_q   : '0;
	end

	// Packet sizing when a header is due
	always_comb begin
		limit      = (regs.max_packet_bytes < 16'(vrpf_pkg::MIN_PACKET)) ?
			16'(vrpf_pkg::MIN_PACKET) : regs.max_packet_bytes;
		cap        = limit - 16'(vrpf_pkg::HDR_BYTES);
		flags.hdr  = (room_cur == '0);
		if (flags.hdr) begin
			room = (rem_cur < LENGTH_BITS'(cap)) ? rem_cur[15:0] : cap;
		end else begin
			room = room_cur;
		end
		room_n     = room - 16'd1;
		rem_n      = rem_cur - LENGTH_BITS'(1);
		flags.pend = (room_n == '0);
		flags.fend = (rem_n == '0);
	end

	assign entry = {payload.data_byte, flags, off_cur, len_cur, counter_q};

	// Position state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			length_q   <= '0;
			offset_q   <= '0;
			remain_q   <= '0;
			room_q     <= '0;
			counter_q  <= '0;
		end else if (push) begin
			if (flags.fend) begin
				in_frame_q <= 1'b0;
				offset_q   <= '0;
				room_q     <= '0;
				counter_q  <= counter_q + 1'b1;
			end else begin
				in_frame_q <= 1'b1;
				length_q   <= len_cur;
				offset_q   <= off_cur + LENGTH_BITS'(1);
				remain_q   <= rem_n;
				room_q     <= room_n;
			end
		end
	end

endmodule

// ===== rtl/core/vrpf_queue.sv =====
// Short register queue between front and back of the fragmenter.
// Depends on vrpf_pkg.
module vrpf_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = vrpf_pkg::QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	input  logic [WIDTH-1:0]           wdata,
	output logic                       full,
	input  logic                       pop,
	output vrpf_pkg::queue_ctl_t       head,
	output logic [WIDTH-1:0]           rdata,
	output logic [$clog2(DEPTH+1)-1:0] count
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head.valid = (count_q != '0);
	assign do_pop     = pop & head.valid;
	assign head.pop   = do_pop;
	assign rdata      = slot_q[rd_ptr_q];
	assign count      = count_q;

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= wdata;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(do_pop);
		end
	end

endmodule

// ===== rtl/core/vrpf_back.sv =====
// Back of the fragmenter: sends the 24 header bytes where a packet starts,
// then the payload beat, through an output register. Depends on vrpf_pkg, vrpf_out_if.
module vrpf_back #(
	parameter int LENGTH_BITS = vrpf_pkg::LENGTH_BITS_DEF,
	parameter int ENTRY_W     = 8 + 3 + 2 * LENGTH_BITS + vrpf_pkg::COUNTER_W
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  vrpf_pkg::cfg_t       regs,
	input  vrpf_pkg::queue_ctl_t head,
	input  logic [ENTRY_W-1:0]   entry,
	output logic                 pop,
	vrpf_out_if.source           packet
);

	logic [7:0]                      data_byte;
	vrpf_pkg::flags_t                flags;
	logic [LENGTH_BITS-1:0]          offset;
	logic [LENGTH_BITS-1:0]          length;
	logic [vrpf_pkg::COUNTER_W-1:0]  counter;

	logic [vrpf_pkg::HDR_IDX_W-1:0]  hdr_idx_q;
	logic                            out_valid_q;
	logic [7:0]                      out_byte_q;
	logic                            pend_q;
	logic                            fend_q;

	logic                            load;
	logic                            in_hdr;
	logic [31:0]                     word;
	logic [7:0]                      hbyte;

	assign {data_byte, flags, offset, length, counter} = entry;

	assign load   = head.valid & (~out_valid_q | packet.ready);
	assign in_hdr = flags.hdr & (hdr_idx_q != 5'(vrpf_pkg::HDR_BYTES));
	assign pop    = load & ~in_hdr;

	// Header word and byte select, most significant byte first
	always_comb begin
		case (hdr_idx_q[4:2])
			3'd0:    word = {regs.tile_index, counter};
			3'd1:    word = 32'(offset);
			3'd2:    word = 32'(length);
			3'd3:    word = {regs.frame_width, regs.frame_height};
			3'd4:    word = vrpf_pkg::FOURCC_AVC1;
			3'd5:    word = {regs.interlace_mode, regs.frame_rate, 3'b000, 1'b1,
				regs.fractional_rate, 14'd0};
			default: word = '0;
		endcase
		case (hdr_idx_q[1:0])
			2'd0:    hbyte = word[31:24];
			2'd1:    hbyte = word[23:16];
			2'd2:    hbyte = word[15:8];
			default: hbyte = word[7:0];
		endcase
	end

	// Header byte counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_idx_q <= '0;
		end else if (load) begin
			hdr_idx_q <= in_hdr ? hdr_idx_q + 1'b1 : '0;
		end
	end

	// Output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (packet.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= in_hdr ? hbyte : data_byte;
			pend_q     <= ~in_hdr & flags.pend;
			fend_q     <= ~in_hdr & flags.fend;
		end
	end

	assign packet.valid      = out_valid_q;
	assign packet.out_byte   = out_byte_q;
	assign packet.packet_end = pend_q;
	assign packet.frame_end  = fend_q;

endmodule

// ===== rtl/core/video_rtp_payload_fragmenter.sv =====
// Top level of the video RTP payload fragmenter.
// Depends on vrpf_pkg, the channel interfaces, vrpf_regs, vrpf_front, vrpf_queue, vrpf_back.
//
// Usage:
//   payload : one frame byte per beat; frame_bytes is read at the first beat
//             of each frame (zero counts as one).
//   packet  : packet bytes; each packet is a 24-byte header followed by up to
//             max(max_packet_bytes, 25)-24 payload bytes. packet_end marks a packet's
//             last byte, frame_end the last byte of a frame.
//   cfg     : register writes (index, data), always ready; write only while
//             the block is idle.
// Order: a payload beat passes through the queue into the output register; when it
//   opens a packet, the 24 header bytes are loaded ahead of it. The receiver can take
//   each loaded beat from the output register.
// Throughput: one output beat per cycle while packet.ready is high. The header of a
//   packet is generated by the back stage from a 5-bit byte counter; while it is sent
//   the two-entry queue fills and payload stalls.
// Reset: registers take their reset values, the frame counter clears and the
//   next beat starts a new frame. When packet.ready is low the output register
//   holds its beat, the queue fills and payload.ready falls.
module video_rtp_payload_fragmenter #(
	parameter int LENGTH_BITS = vrpf_pkg::LENGTH_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	vrpf_in_if.sink     payload,
	vrpf_out_if.source  packet,
	vrpf_cfg_if.sink    cfg
);

	localparam int ENTRY_W = 8 + 3 + 2 * LENGTH_BITS + vrpf_pkg::COUNTER_W;
	localparam int DEPTH   = vrpf_pkg::QUEUE_DEPTH;

	vrpf_pkg::cfg_t                regs;
	vrpf_pkg::queue_ctl_t          head;
	logic                          push;
	logic                          full;
	logic                          pop;
	logic [ENTRY_W-1:0]            wentry;
	logic [ENTRY_W-1:0]            rentry;
	logic [$clog2(DEPTH+1)-1:0]    count;

	vrpf_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	vrpf_front #(.LENGTH_BITS(LENGTH_BITS), .ENTRY_W(ENTRY_W)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.payload (payload),
		.regs    (regs),
		.full    (full),
		.push    (push),
		.entry   (wentry)
	);

	vrpf_queue #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wentry),
		.full   (full),
		.pop    (pop),
		.head   (head),
		.rdata  (rentry),
		.count  (count)
	);

	vrpf_back #(.LENGTH_BITS(LENGTH_BITS), .ENTRY_W(ENTRY_W)) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.regs   (regs),
		.head   (head),
		.entry  (rentry),
		.pop    (pop),
		.packet (packet)
	);

	// The end of a frame always closes its packet
	a_fend_pend: assert property (@(posedge clk) disable iff (!arst_n)
		packet.valid && packet.frame_end |-> packet.packet_end)
		else $error("frame_end without packet_end");

	// Queue never overfills
	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count <= ($clog2(DEPTH+1))'(DEPTH))
		else $error("queue count out of range");

	// A pop only happens while an entry is present
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		head.pop |-> head.valid && count != '0)
		else $error("pop from empty queue");

endmodule

// ===== bench/video_rtp_payload_fragmenter_tb.sv =====
// Self-checking bench for video_rtp_payload_fragmenter: drives frame bytes and register
// writes, predicts every header and payload beat, and compares the packet stream.
// Depends on vrpf_pkg, the channel interfaces and the fragmenter RTL.
module video_rtp_payload_fragmenter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT   = 300000;
	localparam int IDLE_PCT      = 6;
	localparam int CALM_FIRST    = 100;
	localparam int CALM_LAST     = 160;
	localparam int BYTE_TARGET   = 190;

	// Stimulus plan entries
	typedef enum logic [1:0] {
		STEP_BYTE,
		STEP_WRITE,
		STEP_DRAIN
	} step_kind_t;

	typedef struct {
		step_kind_t          kind;
		logic [7:0]          data_byte;
		logic [23:0]         frame_bytes;
		vrpf_pkg::cfg_reg_t  reg_idx;
		logic [15:0]         reg_data;
		int                  seq;
	} plan_step_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       packet_end;
		logic       frame_end;
	} packet_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	vrpf_in_if  payload_ch ();
	vrpf_out_if packet_ch ();
	vrpf_cfg_if cfg_ch ();

	video_rtp_payload_fragmenter dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.payload (payload_ch),
		.packet  (packet_ch),
		.cfg     (cfg_ch)
	);

	plan_step_t   payload_plan[$];
	packet_beat_t packet_beats_due[$];

	// Predictor state: register shadow and frame cutting state
	vrpf_pkg::cfg_t reg_shadow;
	logic        frame_open;
	logic [23:0] frame_len;
	logic [23:0] frame_pos;
	logic [15:0] room_left;
	logic [21:0] frames_done;

	int   mismatches = 0;
	int   cycle_count = 0;
	int   byte_seq = 0;
	int   settle = 0;
	logic calm = 1'b0;

	logic       drv_pvalid;
	logic       drv_cvalid;
	plan_step_t head;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void shadow_reset();
		reg_shadow.max_packet_bytes = 16'd1436;
		reg_shadow.frame_width      = '0;
		reg_shadow.frame_height     = '0;
		reg_shadow.frame_rate       = 10'd25;
		reg_shadow.fractional_rate  = 1'b0;
		reg_shadow.interlace_mode   = '0;
		reg_shadow.tile_index       = '0;
		frame_open  = 1'b0;
		frame_len   = '0;
		frame_pos   = '0;
		room_left   = '0;
		frames_done = '0;
	endfunction

	function automatic void load_register(logic [vrpf_pkg::CFG_IDX_W-1:0] idx,
			logic [15:0] val);
		case (vrpf_pkg::cfg_reg_t'(idx))
			vrpf_pkg::REG_MAX_PACKET: reg_shadow.max_packet_bytes = val;
			vrpf_pkg::REG_WIDTH:      reg_shadow.frame_width = val;
			vrpf_pkg::REG_HEIGHT:     reg_shadow.frame_height = val;
			vrpf_pkg::REG_RATE:       reg_shadow.frame_rate = val[9:0];
			vrpf_pkg::REG_FRACTIONAL: reg_shadow.fractional_rate = val[0];
			vrpf_pkg::REG_INTERLACE:  reg_shadow.interlace_mode = val[2:0];
			vrpf_pkg::REG_TILE:       reg_shadow.tile_index = val[9:0];
			default: ;
		endcase
	endfunction

	// Header words go out most significant byte first
	function automatic void expect_header_word(logic [31:0] w);
		for (int b = 3; b >= 0; b--)
			packet_beats_due.push_back('{w[8*b +: 8], 1'b0, 1'b0});
	endfunction

	// Expected packet beats for one accepted frame byte
	function automatic void fragment_byte(logic [7:0] data, logic [23:0] fbytes);
		logic [16:0] limit;
		logic [15:0] cap;
		logic [23:0] left;
		logic        pend;
		logic        fend;

		if (!frame_open) begin
			frame_len  = (fbytes == '0) ? 24'd1 : fbytes;
			frame_pos  = '0;
			room_left  = '0;
			frame_open = 1'b1;
		end

		// A new packet opens with its header
		if (room_left == '0) begin
			limit = (reg_shadow.max_packet_bytes < vrpf_pkg::MIN_PACKET) ?
				17'(vrpf_pkg::MIN_PACKET) : {1'b0, reg_shadow.max_packet_bytes};
			cap  = 16'(limit - vrpf_pkg::HDR_BYTES);
			left = frame_len - frame_pos;
			room_left = (left < {8'b0, cap}) ? left[15:0] : cap;
			expect_header_word({reg_shadow.tile_index, frames_done});
			expect_header_word({8'b0, frame_pos});
			expect_header_word({8'b0, frame_len});
			expect_header_word({reg_shadow.frame_width, reg_shadow.frame_height});
			expect_header_word(vrpf_pkg::FOURCC_AVC1);
			expect_header_word({reg_shadow.interlace_mode, reg_shadow.frame_rate, 3'b0,
				1'b1, reg_shadow.fractional_rate, 14'b0});
		end

		room_left = room_left - 16'd1;
		frame_pos = frame_pos + 24'd1;
		pend = (room_left == '0);
		fend = (frame_pos >= frame_len);
		packet_beats_due.push_back('{data, pend, fend});

		if (fend) begin
			frame_open  = 1'b0;
			frame_pos   = '0;
			room_left   = '0;
			frames_done = frames_done + 22'd1;
		end
	endfunction

	// Plan builders
	function automatic void plan_write(vrpf_pkg::cfg_reg_t idx, logic [15:0] val);
		plan_step_t s;
		s.kind = STEP_WRITE;
		s.data_byte = '0;
		s.frame_bytes = '0;
		s.reg_idx = idx;
		s.reg_data = val;
		s.seq = 0;
		payload_plan.push_back(s);
	endfunction

	function automatic void plan_drain();
		plan_step_t s;
		s.kind = STEP_DRAIN;
		s.data_byte = '0;
		s.frame_bytes = '0;
		s.reg_idx = vrpf_pkg::REG_MAX_PACKET;
		s.reg_data = '0;
		s.seq = 0;
		payload_plan.push_back(s);
	endfunction

	function automatic void plan_byte(logic [7:0] data, logic [23:0] fbytes);
		plan_step_t s;
		s.kind = STEP_BYTE;
		s.data_byte = data;
		s.frame_bytes = fbytes;
		s.reg_idx = vrpf_pkg::REG_MAX_PACKET;
		s.reg_data = '0;
		s.seq = byte_seq;
		byte_seq++;
		payload_plan.push_back(s);
	endfunction

	// Length is only read on the first byte; later beats carry junk there
	function automatic void plan_frame(logic [23:0] len_field, int count);
		for (int i = 0; i < count; i++)
			plan_byte(8'($urandom), (i == 0) ? len_field : 24'($urandom));
	endfunction

	function automatic logic [15:0] pick_max_packet();
		int r;
		r = $urandom_range(0, 7);
		case (r)
			0: return 16'hffff;
			1: return 16'($urandom_range(0, 24));
			2: return 16'd25;
			3: return 16'($urandom);
			default: return 16'($urandom_range(26, 60));
		endcase
	endfunction

	function automatic logic [15:0] pick_field();
		int r;
		r = $urandom_range(0, 3);
		if (r == 0)
			return 16'h0000;
		else if (r == 1)
			return 16'hffff;
		return 16'($urandom);
	endfunction

	function automatic int pick_frame_len();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 0;
		else if (r <= 6)
			return $urandom_range(1, 12);
		else if (r <= 8)
			return $urandom_range(13, 40);
		return $urandom_range(41, 80);
	endfunction

	// Driver: payload and register beats from the plan
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_ch.valid <= 1'b0;
			cfg_ch.valid <= 1'b0;
			settle <= 0;
			calm <= 1'b0;
		end else begin
			drv_pvalid = payload_ch.valid;
			drv_cvalid = cfg_ch.valid;
			if (payload_ch.valid && payload_ch.ready) begin
				fragment_byte(payload_ch.data_byte, payload_ch.frame_bytes);
				drv_pvalid = 1'b0;
			end
			if (cfg_ch.valid && cfg_ch.ready) begin
				load_register(cfg_ch.index, cfg_ch.data);
				drv_cvalid = 1'b0;
			end

			if (settle != 0) begin
				settle <= settle - 1;
			end else if (!drv_pvalid && !drv_cvalid && payload_plan.size() != 0) begin
				head = payload_plan[0];
				case (head.kind)
					// hold the sender until every predicted beat has left
					STEP_DRAIN: begin
						if (packet_beats_due.size() == 0) begin
							settle <= SETTLE_CYCLES;
							void'(payload_plan.pop_front());
						end
					end
					STEP_WRITE: begin
						cfg_ch.index <= head.reg_idx;
						cfg_ch.data <= head.reg_data;
						drv_cvalid = 1'b1;
						void'(payload_plan.pop_front());
					end
					default: begin
						if ((head.seq >= CALM_FIRST && head.seq < CALM_LAST) ||
								$urandom_range(0, 99) >= IDLE_PCT) begin
							payload_ch.data_byte <= head.data_byte;
							payload_ch.frame_bytes <= head.frame_bytes;
							calm <= (head.seq >= CALM_FIRST && head.seq < CALM_LAST);
							drv_pvalid = 1'b1;
							void'(payload_plan.pop_front());
						end
					end
				endcase
			end
			payload_ch.valid <= drv_pvalid;
			cfg_ch.valid <= drv_cvalid;
		end
	end

	// Monitor: compare each packet beat with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		packet_beat_t want;
		if (!arst_n) begin
			packet_ch.ready <= 1'b0;
		end else begin
			if (packet_ch.valid && packet_ch.ready) begin
				if (packet_beats_due.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected beat: expected none, actual byte %02h pend %0b fend %0b",
						$time, packet_ch.out_byte, packet_ch.packet_end, packet_ch.frame_end);
				end else begin
					want = packet_beats_due.pop_front();
					if (packet_ch.out_byte !== want.out_byte) begin
						mismatches++;
						$display("%0t: out_byte expected %02h actual %02h",
							$time, want.out_byte, packet_ch.out_byte);
					end
					if (packet_ch.packet_end !== want.packet_end) begin
						mismatches++;
						$display("%0t: packet_end expected %0b actual %0b",
							$time, want.packet_end, packet_ch.packet_end);
					end
					if (packet_ch.frame_end !== want.frame_end) begin
						mismatches++;
						$display("%0t: frame_end expected %0b actual %0b",
							$time, want.frame_end, packet_ch.frame_end);
					end
				end
			end
			packet_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Runaway guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		payload_ch.valid = 1'b0;
		payload_ch.data_byte = '0;
		payload_ch.frame_bytes = '0;
		packet_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = vrpf_pkg::REG_MAX_PACKET;
		cfg_ch.data = '0;
		shadow_reset();

		// Reset values: short frame, then a zero length that acts as one
		plan_byte(8'h00, 24'd3);
		plan_byte(8'hff, 24'h000000);
		plan_byte(8'h5a, 24'hffffff);
		plan_byte(8'ha5, 24'd0);

		// All fields at their tops, packet limit below the minimum
		plan_drain();
		plan_write(vrpf_pkg::REG_MAX_PACKET, 16'd0);
		plan_write(vrpf_pkg::REG_WIDTH, 16'hffff);
		plan_write(vrpf_pkg::REG_HEIGHT, 16'hffff);
		plan_write(vrpf_pkg::REG_RATE, 16'hffff);
		plan_write(vrpf_pkg::REG_FRACTIONAL, 16'hffff);
		plan_write(vrpf_pkg::REG_INTERLACE, 16'd7);
		plan_write(vrpf_pkg::REG_TILE, 16'h03ff);
		plan_frame(24'd3, 3);

		// Limit one under the minimum, segmented mode
		plan_drain();
		plan_write(vrpf_pkg::REG_MAX_PACKET, 16'd24);
		plan_write(vrpf_pkg::REG_INTERLACE, 16'd4);
		plan_frame(24'd2, 2);

		// Three-byte packets, then a limit change in the middle of the frame
		plan_drain();
		plan_write(vrpf_pkg::REG_MAX_PACKET, 16'd27);
		plan_frame(24'd7, 4);
		plan_drain();
		plan_write(vrpf_pkg::REG_MAX_PACKET, 16'd26);
		plan_write(vrpf_pkg::REG_RATE, 16'd0);
		plan_write(vrpf_pkg::REG_FRACTIONAL, 16'd0);
		plan_write(vrpf_pkg::REG_INTERLACE, 16'd0);
		plan_write(vrpf_pkg::REG_TILE, 16'd0);
		plan_write(vrpf_pkg::REG_WIDTH, 16'd0);
		plan_write(vrpf_pkg::REG_HEIGHT, 16'd0);
		plan_frame(24'($urandom), 3);

		// Random phases, each with a fresh register set
		while (byte_seq < BYTE_TARGET) begin
			plan_drain();
			plan_write(vrpf_pkg::REG_MAX_PACKET, pick_max_packet());
			plan_write(vrpf_pkg::REG_WIDTH, pick_field());
			plan_write(vrpf_pkg::REG_HEIGHT, pick_field());
			plan_write(vrpf_pkg::REG_RATE, pick_field());
			plan_write(vrpf_pkg::REG_FRACTIONAL, pick_field());
			plan_write(vrpf_pkg::REG_INTERLACE, 16'($urandom_range(0, 7)));
			plan_write(vrpf_pkg::REG_TILE, pick_field());
			repeat ($urandom_range(2, 5)) begin
				int len;
				len = pick_frame_len();
				plan_frame(24'(len), (len == 0) ? 1 : len);
			end
		end

		// Longest frame length: only its opening bytes are sent
		plan_drain();
		plan_write(vrpf_pkg::REG_MAX_PACKET, 16'd30);
		plan_frame(24'hffffff, 8);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (payload_plan.size() != 0 || payload_ch.valid || cfg_ch.valid)
			@(posedge clk);
		while (packet_beats_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0 && packet_beats_due.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
